[hw/rtl/bfhs_pkg.sv]
package bfhs_pkg;

  localparam int DATA_W    = 32;
  localparam int CNT_W     = 7;
  localparam int CFG_W     = 7;
  localparam int STEP_W    = 6;
  localparam int REQ_W     = 3;
  localparam int CFG_IDX_W = 1;

  localparam int STACK_DEPTH_DEF   = 64;
  localparam int HISTORY_DEPTH_DEF = 64;

  localparam logic [CFG_W-1:0] MAX_RESET = CFG_W'(64);

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD_BACK  = 3'd0,
    REQ_ADD_HIST  = 3'd1,
    REQ_GO_BACK   = 3'd2,
    REQ_GO_FWD    = 3'd3,
    REQ_CLR_BACK  = 3'd4,
    REQ_CLR_FWD   = 3'd5,
    REQ_CLR_HIST  = 3'd6,
    REQ_READ_HIST = 3'd7
  } req_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_BACKWARD = 1'b0,
    CFG_MAX_HISTORY  = 1'b1
  } cfg_idx_t;

  // per-ring operation for one cycle
  typedef struct packed {
    logic push;
    logic trim;
    logic pop;
    logic peek;
    logic clear;
  } ring_op_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic add_back;
    logic add_hist;
    logic clr_back;
    logic clr_fwd;
    logic clr_hist;
    logic hist_rd;
    logic mv_start;
    logic mv_xfer;
    logic res_zero;
    logic res_val;
    logic res_capture;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    req_t              req;
    logic              present;
    logic              move_ok;
    logic              hist_ok;
    logic [STEP_W-1:0] steps;
  } dp_stat_t;

endpackage

[hw/rtl/bfhs_ram.sv]
module bfhs_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/bfhs_ring.sv]
module bfhs_ring #(
  parameter int DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bfhs_pkg::ring_op_t             op,
  input  logic [bfhs_pkg::DATA_W-1:0]    push_data,
  input  logic [bfhs_pkg::CFG_W-1:0]     max_lim,
  input  logic [bfhs_pkg::STEP_W-1:0]    offs,
  output logic [$clog2(DEPTH+1)-1:0]     fill,
  output logic [bfhs_pkg::DATA_W-1:0]    rdata
);
  import bfhs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int SW = FW + 1;
  localparam int CW = (FW > CFG_W) ? FW : CFG_W;

  logic [AW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;

  logic          full;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [AW-1:0] head1, head2;
  logic [FW-1:0] fill1, trim_k;
  logic          over;
  logic [SW-1:0] rd_pos;

  // sums here stay below twice the depth
  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] x);
    if (x >= SW'(DEPTH)) begin
      return AW'(x - SW'(DEPTH));
    end
    return AW'(x);
  endfunction

  always_comb begin
    full    = (fill_r == FW'(DEPTH));
    wr_addr = wrap(SW'(head_r) + SW'(fill_r));
    // full ring drops its oldest entry on push
    if (full) begin
      head1 = wrap(SW'(head_r) + SW'(1));
      fill1 = fill_r;
    end else begin
      head1 = head_r;
      fill1 = fill_r + FW'(1);
    end
    over    = CW'(fill1) > CW'(max_lim);
    trim_k  = FW'(CW'(fill1) - CW'(max_lim));
    head2   = wrap(SW'(head1) + SW'(trim_k));
    rd_pos  = SW'(fill_r) - SW'(1) - SW'(offs);
    rd_addr = wrap(SW'(head_r) + rd_pos);

    head_nxt = head_r;
    fill_nxt = fill_r;
    if (op.clear) begin
      head_nxt = '0;
      fill_nxt = '0;
    end else if (op.push) begin
      if (op.trim && over) begin
        head_nxt = head2;
        fill_nxt = FW'(max_lim);
      end else begin
        head_nxt = head1;
        fill_nxt = fill1;
      end
    end else if (op.pop) begin
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign fill = fill_r;

  bfhs_ram #(
    .W     (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (op.push),
    .waddr (wr_addr),
    .wdata (push_data),
    .re    (op.pop | op.peek),
    .raddr (rd_addr),
    .rdata (rdata)
  );

endmodule

[hw/rtl/bfhs_dp.sv]
module bfhs_dp #(
  parameter int STACK_DEPTH   = bfhs_pkg::STACK_DEPTH_DEF,
  parameter int HISTORY_DEPTH = bfhs_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bfhs_pkg::dp_cmd_t               cmd,
  output bfhs_pkg::dp_stat_t              stat,
  input  logic [bfhs_pkg::REQ_W-1:0]      in_req_type,
  input  logic [bfhs_pkg::DATA_W-1:0]     in_entry_id,
  input  logic                            in_entry_present,
  input  logic [bfhs_pkg::STEP_W-1:0]     in_nav_steps,
  input  logic [bfhs_pkg::STEP_W-1:0]     in_history_offset,
  input  logic                            cfg_we,
  input  logic [bfhs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfhs_pkg::CFG_W-1:0]      cfg_wdata,
  output logic [bfhs_pkg::DATA_W-1:0]     res_entry,
  output logic                            res_valid,
  output logic [bfhs_pkg::CNT_W-1:0]      backward_count,
  output logic [bfhs_pkg::CNT_W-1:0]      forward_count,
  output logic [bfhs_pkg::CNT_W-1:0]      history_count
);
  import bfhs_pkg::*;

  localparam int SFW = $clog2(STACK_DEPTH + 1);
  localparam int HFW = $clog2(HISTORY_DEPTH + 1);
  localparam int SCW = SFW + STEP_W;
  localparam int HCW = HFW + STEP_W;

  // latched request
  req_t              req_r;
  logic [DATA_W-1:0] id_r;
  logic              present_r;
  logic [STEP_W-1:0] steps_r;
  logic [STEP_W-1:0] offs_r;

  logic [CFG_W-1:0]  max_back_r, max_hist_r;
  logic [DATA_W-1:0] res_entry_r, res_entry_nxt;
  logic              res_valid_r, res_valid_nxt;

  ring_op_t          back_op, fwd_op, hist_op;
  logic [DATA_W-1:0] back_wdata, fwd_wdata;
  logic [DATA_W-1:0] back_rdata, fwd_rdata, hist_rdata;
  logic [SFW-1:0]    back_fill, fwd_fill;
  logic [HFW-1:0]    hist_fill;
  logic              go_back, go_fwd, moving;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r     <= req_t'(in_req_type);
      id_r      <= in_entry_id;
      present_r <= in_entry_present;
      steps_r   <= in_nav_steps;
      offs_r    <= in_history_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_back_r <= MAX_RESET;
      max_hist_r <= MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_BACKWARD: max_back_r <= cfg_wdata;
        CFG_MAX_HISTORY:  max_hist_r <= cfg_wdata;
        default:          max_back_r <= max_back_r;
      endcase
    end
  end

  assign go_back = (req_r == REQ_GO_BACK);
  assign go_fwd  = (req_r == REQ_GO_FWD);
  assign moving  = cmd.mv_start | cmd.mv_xfer;

  always_comb begin
    back_op       = '0;
    back_op.push  = (cmd.add_back & present_r) | (cmd.mv_start & go_fwd & present_r)
                  | (cmd.mv_xfer & go_fwd);
    back_op.trim  = cmd.add_back;
    back_op.pop   = moving & go_back;
    back_op.clear = cmd.clr_back;
    back_wdata    = cmd.mv_xfer ? fwd_rdata : id_r;

    fwd_op        = '0;
    fwd_op.push   = (cmd.mv_start & go_back & present_r) | (cmd.mv_xfer & go_back);
    fwd_op.pop    = moving & go_fwd;
    fwd_op.clear  = cmd.clr_fwd;
    fwd_wdata     = cmd.mv_xfer ? back_rdata : id_r;

    hist_op       = '0;
    hist_op.push  = cmd.add_hist & present_r;
    hist_op.trim  = cmd.add_hist;
    hist_op.peek  = cmd.hist_rd;
    hist_op.clear = cmd.clr_hist;
  end

  bfhs_ring #(.DEPTH(STACK_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (back_op),
    .push_data (back_wdata),
    .max_lim   (max_back_r),
    .offs      ('0),
    .fill      (back_fill),
    .rdata     (back_rdata)
  );

  bfhs_ring #(.DEPTH(STACK_DEPTH)) u_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (fwd_op),
    .push_data (fwd_wdata),
    .max_lim   ('0),
    .offs      ('0),
    .fill      (fwd_fill),
    .rdata     (fwd_rdata)
  );

  bfhs_ring #(.DEPTH(HISTORY_DEPTH)) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (hist_op),
    .push_data (id_r),
    .max_lim   (max_hist_r),
    .offs      (offs_r),
    .fill      (hist_fill),
    .rdata     (hist_rdata)
  );

  always_comb begin
    stat.req     = req_r;
    stat.present = present_r;
    stat.steps   = steps_r;
    stat.hist_ok = HCW'(offs_r) < HCW'(hist_fill);
    if (go_back) begin
      stat.move_ok = SCW'(steps_r) < SCW'(back_fill);
    end else begin
      stat.move_ok = SCW'(steps_r) < SCW'(fwd_fill);
    end
  end

  always_comb begin
    res_entry_nxt = res_entry_r;
    res_valid_nxt = res_valid_r;
    if (cmd.res_zero) begin
      res_entry_nxt = '0;
      res_valid_nxt = cmd.res_val;
    end else if (cmd.res_capture) begin
      res_valid_nxt = 1'b1;
      case (req_r)
        REQ_GO_BACK: res_entry_nxt = back_rdata;
        REQ_GO_FWD:  res_entry_nxt = fwd_rdata;
        default:     res_entry_nxt = hist_rdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    res_entry_r <= res_entry_nxt;
    res_valid_r <= res_valid_nxt;
  end

  assign res_entry      = res_entry_r;
  assign res_valid      = res_valid_r;
  assign backward_count = CNT_W'(back_fill);
  assign forward_count  = CNT_W'(fwd_fill);
  assign history_count  = CNT_W'(hist_fill);

endmodule

[hw/rtl/bfhs_ctrl.sv]
module bfhs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_strobe,
  input  bfhs_pkg::dp_stat_t stat,
  output bfhs_pkg::dp_cmd_t  cmd
);
  import bfhs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DISP = 5'b00010,
    S_HRD  = 5'b00100,
    S_MOVE = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic              idle;

  assign idle       = (state_r == S_IDLE) || (state_r == S_DONE);
  assign busy       = !idle;
  assign out_strobe = (state_r == S_DONE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r) inside
      S_IDLE, S_DONE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DISP: begin
        state_nxt = S_DONE;
        unique case (stat.req) inside
          REQ_ADD_BACK: begin
            cmd.add_back = 1'b1;
            cmd.res_zero = 1'b1;
            cmd.res_val  = stat.present;
          end
          REQ_ADD_HIST: begin
            cmd.add_hist = 1'b1;
            cmd.res_zero = 1'b1;
            cmd.res_val  = stat.present;
          end
          REQ_GO_BACK, REQ_GO_FWD: begin
            if (stat.move_ok) begin
              cmd.mv_start = 1'b1;
              cnt_nxt      = stat.steps;
              state_nxt    = S_MOVE;
            end else begin
              cmd.res_zero = 1'b1;
            end
          end
          REQ_CLR_BACK: begin
            cmd.clr_back = 1'b1;
            cmd.res_zero = 1'b1;
            cmd.res_val  = 1'b1;
          end
          REQ_CLR_FWD: begin
            cmd.clr_fwd  = 1'b1;
            cmd.res_zero = 1'b1;
            cmd.res_val  = 1'b1;
          end
          REQ_CLR_HIST: begin
            cmd.clr_hist = 1'b1;
            cmd.res_zero = 1'b1;
            cmd.res_val  = 1'b1;
          end
          REQ_READ_HIST: begin
            if (stat.hist_ok) begin
              cmd.hist_rd = 1'b1;
              state_nxt   = S_HRD;
            end else begin
              cmd.res_zero = 1'b1;
            end
          end
          default: cmd.res_zero = 1'b1;
        endcase
      end
      S_HRD: begin
        cmd.res_capture = 1'b1;
        state_nxt       = S_DONE;
      end
      S_MOVE: begin
        // read data is the entry popped last cycle
        if (cnt_r == '0) begin
          cmd.res_capture = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          cmd.mv_xfer = 1'b1;
          cnt_nxt     = cnt_r - STEP_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/back_forward_history_stacks.sv]
// sequence: accept, decode (S_DISP), result strobe (S_DONE) for add, clear, failed;
//   read history adds the registered ring read (S_HRD) before the strobe, go back /
//   go forward add the move (S_MOVE, one entry per cycle); next item accepted in the
//   strobe cycle, busy is high from decode until the strobe, so one item at a time
// reset (rst_n, synchronous): all three stores empty, both limits 64, idle
// results are shown for one cycle on out_strobe; the receiver cannot stall
module back_forward_history_stacks #(
  parameter int STACK_DEPTH   = bfhs_pkg::STACK_DEPTH_DEF,
  parameter int HISTORY_DEPTH = bfhs_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            start,
  output logic                            busy,
  input  logic [bfhs_pkg::REQ_W-1:0]      in_req_type,
  input  logic [bfhs_pkg::DATA_W-1:0]     in_entry_id,
  input  logic                            in_entry_present,
  input  logic [bfhs_pkg::STEP_W-1:0]     in_nav_steps,
  input  logic [bfhs_pkg::STEP_W-1:0]     in_history_offset,
  // result channel
  output logic                            out_strobe,
  output logic [bfhs_pkg::DATA_W-1:0]     out_result_entry,
  output logic                            out_result_valid,
  output logic [bfhs_pkg::CNT_W-1:0]      out_backward_count,
  output logic [bfhs_pkg::CNT_W-1:0]      out_forward_count,
  output logic [bfhs_pkg::CNT_W-1:0]      out_history_count,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [bfhs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfhs_pkg::CFG_W-1:0]      cfg_wdata
);
  import bfhs_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: decodes the latched request, walks multi-step moves
  // with a down counter, one pop and one push per cycle
  bfhs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath: request latch, limit registers, three ring stores
  // (head and fill pointers over a registered-read memory each)
  // and the result register; counts come straight from the fills
  bfhs_dp #(
    .STACK_DEPTH   (STACK_DEPTH),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_req_type       (in_req_type),
    .in_entry_id       (in_entry_id),
    .in_entry_present  (in_entry_present),
    .in_nav_steps      (in_nav_steps),
    .in_history_offset (in_history_offset),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .res_entry         (out_result_entry),
    .res_valid         (out_result_valid),
    .backward_count    (out_backward_count),
    .forward_count     (out_forward_count),
    .history_count     (out_history_count)
  );

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import bfhs_pkg::*;

  // model copies: one tracks what has been queued, one tracks what the block has taken
  localparam int PLAN = 0;
  localparam int PRED = 1;

  // store numbers inside the model arrays
  localparam int ST_BACK = 0;
  localparam int ST_FWD  = 1;
  localparam int ST_HIST = 2;

  localparam int RING_SLOTS = 64;
  localparam int IDLE_LIMIT = 3000;
  localparam int PHASE_ITEMS = 180;

  // one request item as the sender drives it
  typedef struct packed {
    req_t              req;
    logic [DATA_W-1:0] id;
    logic              present;
    logic [STEP_W-1:0] steps;
    logic [STEP_W-1:0] offs;
  } request_t;

  // one result item as the block reports it
  typedef struct packed {
    logic [DATA_W-1:0] entry;
    logic              valid;
    logic [CNT_W-1:0]  back_cnt;
    logic [CNT_W-1:0]  fwd_cnt;
    logic [CNT_W-1:0]  hist_cnt;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              start = 1'b0;
  logic              busy;
  logic [REQ_W-1:0]  in_req_type = '0;
  logic [DATA_W-1:0] in_entry_id = '0;
  logic              in_entry_present = 1'b0;
  logic [STEP_W-1:0] in_nav_steps = '0;
  logic [STEP_W-1:0] in_history_offset = '0;

  logic              out_strobe;
  logic [DATA_W-1:0] out_result_entry;
  logic              out_result_valid;
  logic [CNT_W-1:0]  out_backward_count;
  logic [CNT_W-1:0]  out_forward_count;
  logic [CNT_W-1:0]  out_history_count;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // model state, indexed by copy and store
  logic [DATA_W-1:0] ring_mem [2][3][RING_SLOTS];
  int                ring_head [2][3];
  int                ring_fill [2][3];
  int                limit_of [2][3];

  request_t pending_requests [$];
  outcome_t expected_outcomes [$];
  request_t cur_request;

  int items_queued = 0;
  int results_seen = 0;
  int fail_count = 0;
  int gap_left = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  back_forward_history_stacks uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_entry_id       (in_entry_id),
    .in_entry_present  (in_entry_present),
    .in_nav_steps      (in_nav_steps),
    .in_history_offset (in_history_offset),
    .out_strobe        (out_strobe),
    .out_result_entry  (out_result_entry),
    .out_result_valid  (out_result_valid),
    .out_backward_count(out_backward_count),
    .out_forward_count (out_forward_count),
    .out_history_count (out_history_count),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // store primitives of the behavioral model
  // ---------------------------------------------------------------

  // discard the oldest entry of a store, if there is one
  function automatic void drop_oldest(input int inst, input int s);
    if (ring_fill[inst][s] > 0) begin
      ring_head[inst][s] = (ring_head[inst][s] + 1) % RING_SLOTS;
      ring_fill[inst][s]--;
    end
  endfunction

  // push on top; a full store loses its oldest entry first
  function automatic void push_handle(input int inst, input int s, input logic [DATA_W-1:0] v);
    if (ring_fill[inst][s] >= RING_SLOTS) drop_oldest(inst, s);
    ring_mem[inst][s][(ring_head[inst][s] + ring_fill[inst][s]) % RING_SLOTS] = v;
    ring_fill[inst][s]++;
  endfunction

  // take the newest entry; callers make sure the store is not empty
  function automatic logic [DATA_W-1:0] pop_handle(input int inst, input int s);
    ring_fill[inst][s]--;
    return ring_mem[inst][s][(ring_head[inst][s] + ring_fill[inst][s]) % RING_SLOTS];
  endfunction

  // apply one request to a model copy and work out the result it gives
  function automatic void apply_request(input int inst, input request_t r, output outcome_t o);
    int s;
    int src;
    int dst;
    o = '0;
    case (r.req) inside
      REQ_ADD_BACK, REQ_ADD_HIST: begin
        s = (r.req == REQ_ADD_BACK) ? ST_BACK : ST_HIST;
        if (r.present) begin
          push_handle(inst, s, r.id);
          // the limit is looked at only here, so a lowered limit bites at the next add
          while (ring_fill[inst][s] > limit_of[inst][s]) drop_oldest(inst, s);
          o.valid = 1'b1;
        end
      end
      REQ_GO_BACK, REQ_GO_FWD: begin
        src = (r.req == REQ_GO_BACK) ? ST_BACK : ST_FWD;
        dst = (r.req == REQ_GO_BACK) ? ST_FWD : ST_BACK;
        // out-of-range step count leaves everything alone
        if (int'(r.steps) < ring_fill[inst][src]) begin
          if (r.present) push_handle(inst, dst, r.id);
          for (int i = 0; i < int'(r.steps); i++)
            push_handle(inst, dst, pop_handle(inst, src));
          o.entry = pop_handle(inst, src);
          o.valid = 1'b1;
        end
      end
      REQ_CLR_BACK, REQ_CLR_FWD, REQ_CLR_HIST: begin
        s = (r.req == REQ_CLR_BACK) ? ST_BACK : (r.req == REQ_CLR_FWD) ? ST_FWD : ST_HIST;
        ring_head[inst][s] = 0;
        ring_fill[inst][s] = 0;
        o.valid = 1'b1;
      end
      default: begin
        // read history, counted down from the newest entry
        if (int'(r.offs) < ring_fill[inst][ST_HIST]) begin
          o.entry = ring_mem[inst][ST_HIST][(ring_head[inst][ST_HIST] +
                    ring_fill[inst][ST_HIST] - 1 - int'(r.offs)) % RING_SLOTS];
          o.valid = 1'b1;
        end
      end
    endcase
    o.back_cnt = CNT_W'(ring_fill[inst][ST_BACK]);
    o.fwd_cnt  = CNT_W'(ring_fill[inst][ST_FWD]);
    o.hist_cnt = CNT_W'(ring_fill[inst][ST_HIST]);
  endfunction

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------

  // every field random, req included
  function automatic request_t random_request();
    request_t r;
    r.req     = req_t'($urandom_range(0, 7));
    r.id      = $urandom();
    r.present = 1'($urandom_range(0, 1));
    r.steps   = STEP_W'($urandom_range(0, 63));
    r.offs    = STEP_W'($urandom_range(0, 63));
    return r;
  endfunction

  function automatic request_t make_request(input req_t q, input logic [DATA_W-1:0] id,
                                            input logic present, input int steps,
                                            input int offs);
    request_t r;
    r.req     = q;
    r.id      = id;
    r.present = present;
    r.steps   = STEP_W'(steps);
    r.offs    = STEP_W'(offs);
    return r;
  endfunction

  // hand an item to the driver; the planning copy follows along so that
  // later random items can be aimed at the current fill levels
  function automatic void queue_request(input request_t r);
    outcome_t scratch;
    apply_request(PLAN, r, scratch);
    pending_requests = {pending_requests, r};
    items_queued++;
  endfunction

  // random traffic, mostly well-formed runs: fills, moves in range, reads in range
  task automatic queue_random(input int n);
    int made;
    int pick;
    int runs;
    int cnt;
    int src;
    logic hist_side;
    request_t r;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // fill run, now and then long enough to overflow a full store
        runs = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 10);
        hist_side = 1'($urandom_range(0, 1));
        for (int i = 0; i < runs; i++) begin
          r = random_request();
          r.req = hist_side ? REQ_ADD_HIST : REQ_ADD_BACK;
          r.present = ($urandom_range(0, 15) != 0);
          queue_request(r);
        end
        made += runs;
      end else if (pick < 60) begin
        // a few moves, step counts mostly inside the source stack
        runs = $urandom_range(1, 6);
        for (int i = 0; i < runs; i++) begin
          r = random_request();
          r.req = ($urandom_range(0, 1) != 0) ? REQ_GO_FWD : REQ_GO_BACK;
          src = (r.req == REQ_GO_BACK) ? ST_BACK : ST_FWD;
          cnt = ring_fill[PLAN][src];
          if (cnt > 0 && $urandom_range(0, 7) != 0) begin
            if ($urandom_range(0, 1) != 0)
              r.steps = STEP_W'($urandom_range(0, (cnt - 1 < 3) ? cnt - 1 : 3));
            else
              r.steps = STEP_W'($urandom_range(0, cnt - 1));
          end else if (cnt < RING_SLOTS) begin
            r.steps = STEP_W'($urandom_range(cnt, 63));
          end
          r.present = ($urandom_range(0, 3) != 0);
          queue_request(r);
        end
        made += runs;
      end else if (pick < 75) begin
        r = random_request();
        r.req = REQ_READ_HIST;
        cnt = ring_fill[PLAN][ST_HIST];
        if (cnt > 0 && $urandom_range(0, 7) != 0) r.offs = STEP_W'($urandom_range(0, cnt - 1));
        queue_request(r);
        made++;
      end else if (pick < 81) begin
        r = random_request();
        r.req = req_t'($urandom_range(int'(REQ_CLR_BACK), int'(REQ_CLR_HIST)));
        queue_request(r);
        made++;
      end else begin
        // noise: anything the fields allow
        queue_request(random_request());
        made++;
      end
    end
  endtask

  // every item gives one result, so all results in means the block is idle
  task automatic wait_drained();
    while (results_seen != items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // limit write while idle; both model copies take the new value at once
  task automatic write_limit(input cfg_idx_t idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    if (idx == CFG_MAX_BACKWARD) begin
      limit_of[PLAN][ST_BACK] = val;
      limit_of[PRED][ST_BACK] = val;
    end else begin
      limit_of[PLAN][ST_HIST] = val;
      limit_of[PRED][ST_HIST] = val;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // ---------------------------------------------------------------
  // driver: bursts of items with random gaps, ports held while busy
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      // item taken at this edge: predict its result now
      if (start && !busy) begin
        apply_request(PRED, cur_request, want);
        expected_outcomes = {expected_outcomes, want};
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          cur_request = pending_requests.pop_front();
          in_req_type       <= cur_request.req;
          in_entry_id       <= cur_request.id;
          in_entry_present  <= cur_request.present;
          in_nav_steps      <= cur_request.steps;
          in_history_offset <= cur_request.offs;
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // next burst: often no gap at all, sometimes a long one
            burst_left = $urandom_range(0, 23);
            case ($urandom_range(0, 7)) inside
              0, 1, 2, 3: gap_left = $urandom_range(0, 3);
              4, 5:       gap_left = 0;
              6:          gap_left = $urandom_range(5, 20);
              default:    gap_left = $urandom_range(30, 40);
            endcase
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // monitor: each strobed item against the oldest expectation
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_strobe) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t unexpected result item: expected none, actual entry %h valid %b",
                 $time, out_result_entry, out_result_valid);
        fail_count++;
      end else begin
        want = expected_outcomes.pop_front();
        check_field("result_entry", want.entry, out_result_entry);
        check_field("result_valid", DATA_W'(want.valid), DATA_W'(out_result_valid));
        check_field("backward_count", DATA_W'(want.back_cnt), DATA_W'(out_backward_count));
        check_field("forward_count", DATA_W'(want.fwd_cnt), DATA_W'(out_forward_count));
        check_field("history_count", DATA_W'(want.hist_cnt), DATA_W'(out_history_count));
      end
      results_seen++;
    end
  end

  // watchdog: too long without any item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t timeout: nothing accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL back_forward_history_stacks");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // sequence: reset, directed items, then phases of limits and random items
  // ---------------------------------------------------------------
  initial begin
    int back_lims [8];
    int hist_lims [8];
    for (int c = 0; c < 2; c++) begin
      for (int s = 0; s < 3; s++) begin
        ring_head[c][s] = 0;
        ring_fill[c][s] = 0;
        limit_of[c][s]  = int'(MAX_RESET);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // empty stores: reads and moves give null
    queue_request(make_request(REQ_READ_HIST, 32'h0, 1'b0, 0, 0));
    queue_request(make_request(REQ_GO_BACK, 32'h1111_2222, 1'b1, 0, 0));
    queue_request(make_request(REQ_GO_FWD, 32'h3333_4444, 1'b1, 0, 0));
    // adds of a null handle change nothing
    queue_request(make_request(REQ_ADD_BACK, 32'hdead_beef, 1'b0, 0, 0));
    queue_request(make_request(REQ_ADD_HIST, 32'hdead_beef, 1'b0, 0, 0));
    // extreme handles
    queue_request(make_request(REQ_ADD_BACK, 32'hffff_ffff, 1'b1, 63, 63));
    queue_request(make_request(REQ_ADD_BACK, 32'h0000_0000, 1'b1, 0, 0));
    queue_request(make_request(REQ_ADD_BACK, 32'h1234_5678, 1'b1, 0, 0));
    queue_request(make_request(REQ_ADD_HIST, 32'hffff_ffff, 1'b1, 0, 0));
    queue_request(make_request(REQ_ADD_HIST, 32'h0000_0000, 1'b1, 0, 0));
    queue_request(make_request(REQ_ADD_HIST, 32'h89ab_cdef, 1'b1, 0, 0));
    // history reads: newest, oldest, just past the end, far past it
    queue_request(make_request(REQ_READ_HIST, 32'h0, 1'b0, 0, 0));
    queue_request(make_request(REQ_READ_HIST, 32'h0, 1'b0, 0, 2));
    queue_request(make_request(REQ_READ_HIST, 32'h0, 1'b0, 0, 3));
    queue_request(make_request(REQ_READ_HIST, 32'hffff_ffff, 1'b1, 63, 63));
    // step count equal to the fill is out of range
    queue_request(make_request(REQ_GO_BACK, 32'h5555_aaaa, 1'b1, 3, 0));
    // multi-step back with a current handle, then forward without one
    queue_request(make_request(REQ_GO_BACK, 32'hcafe_f00d, 1'b1, 1, 0));
    queue_request(make_request(REQ_GO_FWD, 32'h7777_7777, 1'b0, 0, 0));
    queue_request(make_request(REQ_GO_FWD, 32'h5a5a_5a5a, 1'b1, 0, 0));
    queue_request(make_request(REQ_GO_FWD, 32'h0, 1'b1, 0, 0));
    // multi-step back with no current handle
    queue_request(make_request(REQ_GO_BACK, 32'h0, 1'b0, 1, 0));
    // clears, then a read of the emptied history
    queue_request(make_request(REQ_CLR_BACK, 32'h0, 1'b0, 0, 0));
    queue_request(make_request(REQ_CLR_FWD, 32'h0, 1'b0, 0, 0));
    queue_request(make_request(REQ_CLR_HIST, 32'h0, 1'b0, 0, 0));
    queue_request(make_request(REQ_READ_HIST, 32'h0, 1'b1, 0, 0));
    wait_drained();

    // limit settings per phase: zero, one, above depth, depth, odd pairs, random
    back_lims = '{0, 1, 127, 64, 2, 40, 64, 0};
    hist_lims = '{0, 127, 1, 64, 63, 3, 64, 0};
    back_lims[7] = $urandom_range(0, 127);
    hist_lims[7] = $urandom_range(0, 127);
    for (int p = 0; p < 8; p++) begin
      write_limit(CFG_MAX_BACKWARD, back_lims[p]);
      write_limit(CFG_MAX_HISTORY, hist_lims[p]);
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    // let any stray result show up before the verdict
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS back_forward_history_stacks");
    end else begin
      $display("FAIL back_forward_history_stacks");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/bfhs_pkg.sv
hw/rtl/bfhs_ram.sv
hw/rtl/bfhs_ring.sv
hw/rtl/bfhs_dp.sv
hw/rtl/bfhs_ctrl.sv
hw/rtl/back_forward_history_stacks.sv
bench/testbench.sv
